// ===== rtl/tdep_pkg.sv =====
// ----------------------------------------------------------------------------
// tdep_pkg
// Shared types and constants of the two-device expert placer.
// ----------------------------------------------------------------------------
package tdep_pkg;

  localparam int MaxExperts = 64;
  localparam int FracBits   = 16;

  localparam int IdW    = 16;
  localparam int TimeW  = 63;
  localparam int SizeW  = 48;
  localparam int TotW   = 54;
  localparam int RateW  = 32;
  localparam int LoadW  = 64;
  localparam int CfgW   = 48;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_DEV0_FREE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DEV1_FREE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DEV0_RATE = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_DEV1_RATE = 2'd3;

  typedef struct packed {
    logic [IdW-1:0]   expert_id;
    logic             hot;
    logic [TimeW-1:0] recent_ns;
    logic [SizeW-1:0] size_bytes;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0]   expert_id_res;
    logic             device;
    logic [SizeW-1:0] size_bytes_res;
    logic             over_budget;
    logic [TotW-1:0]  dev0_bytes_total;
    logic [TotW-1:0]  dev1_bytes_total;
    logic [6:0]       dev0_count;
    logic [6:0]       dev1_count;
    logic             last_res;
  } out_item_t;

  // sort key and payload held in one cell
  typedef struct packed {
    logic             hot;
    logic [TimeW-1:0] recent_ns;
    logic [SizeW-1:0] size_bytes;
    logic [IdW-1:0]   expert_id;
  } entry_t;

  // true if a must come before b
  function automatic logic ranks_before(input entry_t a, input entry_t b);
    logic r;
    if (a.hot != b.hot) r = a.hot;
    else if (a.recent_ns != b.recent_ns) r = a.recent_ns > b.recent_ns;
    else if (a.size_bytes != b.size_bytes) r = a.size_bytes > b.size_bytes;
    else r = a.expert_id < b.expert_id;
    return r;
  endfunction

endpackage

// ===== rtl/tdep_cell.sv =====
// ----------------------------------------------------------------------------
// tdep_cell
// One sorting cell: compares the new item with its own entry and takes either
// the new item or the entry of the cell above; in drain mode shifts its entry
// toward the head of the chain.
// ----------------------------------------------------------------------------
module tdep_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ins,
  input  logic              shift,
  input  tdep_pkg::entry_t  in_e,
  input  tdep_pkg::entry_t  up_e,
  input  logic              up_v,
  input  logic              up_take,
  input  tdep_pkg::entry_t  nb_e,
  input  logic              nb_v,
  output logic              take_o,
  output tdep_pkg::entry_t  e_o,
  output logic              v_o
);
  tdep_pkg::entry_t e_r, e_nxt;
  logic             v_r, v_nxt;
  logic             take;

  // new item goes here or below only if strictly before (keeps arrival order)
  assign take   = !v_r || tdep_pkg::ranks_before(in_e, e_r);
  assign take_o = take;
  assign e_o    = e_r;
  assign v_o    = v_r;

  always_comb begin
    e_nxt = e_r;
    v_nxt = v_r;
    if (shift) begin
      e_nxt = nb_e;
      v_nxt = nb_v;
    end else if (ins && up_take) begin
      e_nxt = up_e;
      v_nxt = up_v;
    end else if (ins && take) begin
      e_nxt = in_e;
      v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    e_r <= e_nxt;
  end
endmodule

// ===== rtl/tdep_div.sv =====
// ----------------------------------------------------------------------------
// tdep_div
// Restoring divider: floor(size * 2^(2F) / rate), one quotient bit a cycle,
// saturated to 64 bits. done rises the cycle after the last quotient bit.
// ----------------------------------------------------------------------------
module tdep_div #(
  parameter int FRAC_BITS = tdep_pkg::FracBits
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [tdep_pkg::SizeW-1:0]    size,
  input  logic [tdep_pkg::RateW-1:0]    rate,
  output logic                          done,
  output logic [tdep_pkg::LoadW-1:0]    q
);
  localparam int Total = tdep_pkg::SizeW + 2 * FRAC_BITS;
  localparam int CntW  = $clog2(Total + 1);

  logic [Total-1:0]          num_r;
  logic [tdep_pkg::RateW:0]  rem_r;
  logic [tdep_pkg::RateW-1:0] d_r;
  logic [tdep_pkg::LoadW-1:0] q_r;
  logic                       sat_r;
  logic [CntW-1:0]            cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [tdep_pkg::RateW+1:0] sh;
  logic                       qb;

  assign sh   = {rem_r, num_r[Total-1]};
  assign qb   = sh >= {2'b00, d_r};
  assign done = done_r;
  assign q    = sat_r ? '1 : q_r;

  // step one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(Total);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (go) begin
      num_r <= {size, {(2*FRAC_BITS){1'b0}}};
      rem_r <= '0;
      d_r   <= (rate == '0) ? tdep_pkg::RateW'(1 << FRAC_BITS) : rate;
      q_r   <= '0;
      sat_r <= 1'b0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= qb ? (tdep_pkg::RateW+1)'(sh - {2'b00, d_r}) : sh[tdep_pkg::RateW:0];
      if (q_r[tdep_pkg::LoadW-1]) sat_r <= 1'b1;
      q_r   <= {q_r[tdep_pkg::LoadW-2:0], qb};
    end
  end
endmodule

// ===== rtl/two_device_expert_placer_core.sv =====
// ----------------------------------------------------------------------------
// two_device_expert_placer_core
// Collects expert descriptors in a sorting chain of cells, then places each
// on one of two devices by free budget and projected time (by load so far
// when neither has room). Descriptors are taken while idle; after the last
// one is taken, each placement waits on two serial divisions, device 0 then
// device 1, and the block takes no new descriptor until the batch is placed;
// busy stays high through the cycle that shows the final placement, and
// the receiver cannot stall.
// Reset is synchronous: clears the chain, counters and registers to defaults.
// ----------------------------------------------------------------------------
module two_device_expert_placer_core #(
  parameter int MAX_EXPERTS = tdep_pkg::MaxExperts,
  parameter int FRAC_BITS   = tdep_pkg::FracBits
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  tdep_pkg::in_item_t            in_item,
  output logic                          out_valid,
  output tdep_pkg::out_item_t           out_item,
  input  logic                          cfg_we,
  input  logic [tdep_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [tdep_pkg::CfgW-1:0]     cfg_data
);
  localparam int CntW = $clog2(MAX_EXPERTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_DIV0, S_DIV1, S_EMIT} state_t;

  state_t state_r;
  logic [tdep_pkg::SizeW-1:0] free0_r, free1_r;
  logic [tdep_pkg::RateW-1:0] rate0_r, rate1_r;
  logic [CntW-1:0] held_r, left_r;
  logic [tdep_pkg::LoadW-1:0] load0_r, load1_r, t0_r;
  logic [tdep_pkg::TotW-1:0]  b0_r, b1_r;
  logic [6:0] n0_r, n1_r;
  logic out_valid_r;
  tdep_pkg::out_item_t out_r;

  // chain wiring
  tdep_pkg::entry_t new_e;
  tdep_pkg::entry_t he [MAX_EXPERTS];
  logic             hv [MAX_EXPERTS];
  logic             tk [MAX_EXPERTS];
  tdep_pkg::entry_t ue [MAX_EXPERTS];
  logic             uv [MAX_EXPERTS];
  logic             ut [MAX_EXPERTS];
  tdep_pkg::entry_t nbe [MAX_EXPERTS];
  logic             nbv [MAX_EXPERTS];
  logic accept, ins, shift, dgo, ddone;
  logic [tdep_pkg::LoadW-1:0] dq;
  tdep_pkg::entry_t head;

  assign accept = start && !busy;
  assign ins    = accept && (held_r < CntW'(MAX_EXPERTS));
  assign new_e  = '{hot: in_item.hot, recent_ns: in_item.recent_ns,
                    size_bytes: in_item.size_bytes, expert_id: in_item.expert_id};
  assign head   = he[0];

  genvar g;
  generate
    for (g = 0; g < MAX_EXPERTS; g++) begin : g_cell
      if (g == 0) begin : g_top
        assign ue[g] = new_e;
        assign uv[g] = 1'b0;
        assign ut[g] = 1'b0;
      end else begin : g_below
        assign ue[g] = he[g-1];
        assign uv[g] = hv[g-1];
        assign ut[g] = tk[g-1];
      end
      if (g == MAX_EXPERTS - 1) begin : g_end
        assign nbe[g] = he[g];
        assign nbv[g] = 1'b0;
      end else begin : g_mid
        assign nbe[g] = he[g+1];
        assign nbv[g] = hv[g+1];
      end
      tdep_cell u_cell (
        .clk(clk), .rst_n(rst_n), .ins(ins), .shift(shift),
        .in_e(new_e), .up_e(ue[g]), .up_v(uv[g]), .up_take(ut[g]),
        .nb_e(nbe[g]), .nb_v(nbv[g]),
        .take_o(tk[g]), .e_o(he[g]), .v_o(hv[g])
      );
    end
  endgenerate

  // placement decision
  logic [tdep_pkg::TotW:0] s0, s1;
  logic can0, can1, dev, over;
  logic [tdep_pkg::LoadW:0] p0, p1;
  logic [tdep_pkg::LoadW-1:0] ps0, ps1;
  assign s0 = {1'b0, b0_r} + (tdep_pkg::TotW+1)'(head.size_bytes);
  assign s1 = {1'b0, b1_r} + (tdep_pkg::TotW+1)'(head.size_bytes);
  assign can0 = s0 <= (tdep_pkg::TotW+1)'(free0_r);
  assign can1 = s1 <= (tdep_pkg::TotW+1)'(free1_r);
  assign p0 = {1'b0, load0_r} + {1'b0, t0_r};
  assign p1 = {1'b0, load1_r} + {1'b0, dq};
  assign ps0 = p0[tdep_pkg::LoadW] ? '1 : p0[tdep_pkg::LoadW-1:0];
  assign ps1 = p1[tdep_pkg::LoadW] ? '1 : p1[tdep_pkg::LoadW-1:0];
  assign over = !can0 && !can1;
  always_comb begin
    if (!can0 && can1) dev = 1'b1;
    else if (can0 && !can1) dev = 1'b0;
    else if (over) dev = !(load0_r <= load1_r);
    else dev = !(ps0 <= ps1);
  end

  // launch the device 0 division once the head is settled, device 1 right after
  assign busy  = (state_r != S_IDLE);
  assign dgo   = (state_r == S_EMIT && left_r != '0) ||
                 (state_r == S_DIV0 && ddone);
  assign shift = (state_r == S_DIV1) && ddone;

  tdep_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo),
    .size(head.size_bytes),
    .rate((state_r == S_DIV0) ? rate1_r : rate0_r),
    .done(ddone), .q(dq)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // hold registers, sequence placement
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_r  <= '0;
      left_r  <= '0;
      free0_r <= '0;
      free1_r <= '0;
      rate0_r <= tdep_pkg::RateW'(1 << FRAC_BITS);
      rate1_r <= tdep_pkg::RateW'(1 << FRAC_BITS);
      load0_r <= '0; load1_r <= '0;
      b0_r <= '0; b1_r <= '0; n0_r <= '0; n1_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          tdep_pkg::REG_DEV0_FREE: free0_r <= cfg_data;
          tdep_pkg::REG_DEV1_FREE: free1_r <= cfg_data;
          tdep_pkg::REG_DEV0_RATE: rate0_r <= cfg_data[tdep_pkg::RateW-1:0];
          tdep_pkg::REG_DEV1_RATE: rate1_r <= cfg_data[tdep_pkg::RateW-1:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (ins) held_r <= held_r + 1'b1;
            if (in_item.last) begin
              left_r  <= ins ? held_r + 1'b1 : held_r;
              state_r <= S_EMIT;
            end
          end
        end
        S_DIV0: begin
          if (ddone) begin
            t0_r    <= dq;
            state_r <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (ddone) begin
            out_valid_r <= 1'b1;
            out_r.expert_id_res  <= head.expert_id;
            out_r.device         <= dev;
            out_r.size_bytes_res <= head.size_bytes;
            out_r.over_budget    <= over;
            out_r.dev0_bytes_total <= dev ? b0_r : s0[tdep_pkg::TotW-1:0];
            out_r.dev1_bytes_total <= dev ? s1[tdep_pkg::TotW-1:0] : b1_r;
            out_r.dev0_count <= dev ? n0_r : n0_r + 1'b1;
            out_r.dev1_count <= dev ? n1_r + 1'b1 : n1_r;
            out_r.last_res   <= (left_r == CntW'(1));
            if (dev) begin
              b1_r <= s1[tdep_pkg::TotW-1:0]; n1_r <= n1_r + 1'b1; load1_r <= ps1;
            end else begin
              b0_r <= s0[tdep_pkg::TotW-1:0]; n0_r <= n0_r + 1'b1; load0_r <= ps0;
            end
            left_r  <= left_r - 1'b1;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (left_r == '0) begin
            held_r <= '0;
            load0_r <= '0; load1_r <= '0;
            b0_r <= '0; b1_r <= '0; n0_r <= '0; n1_r <= '0;
            state_r <= S_IDLE;
          end else begin
            state_r <= S_DIV0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside placement");
  a_held_cap: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CntW'(MAX_EXPERTS)) else $error("held count overflow");
  a_one_dev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.dev0_count + out_item.dev1_count) != 8'd0)
    else $error("count mismatch");
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Two-device expert placer testbench
// Sends batches of expert descriptors through the start/busy port and checks
// each placement against a sorting and placement predictor of its own. A
// short table of directed rows comes first, then random batches under several
// register settings, including the extremes of budgets and rates.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WatchLimit = 5000;
  localparam int SettleCycles = 200;
  localparam int Batches = 12;

  typedef struct {
    tdep_pkg::in_item_t  item;
    bit                  typed;
    tdep_pkg::out_item_t res;
  } row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  tdep_pkg::in_item_t            in_item = '0;
  logic                          out_valid;
  tdep_pkg::out_item_t           out_item;
  logic                          cfg_we = 1'b0;
  logic [tdep_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [tdep_pkg::CfgW-1:0]     cfg_data = '0;

  // model state
  logic [tdep_pkg::SizeW-1:0]    free0, free1;
  logic [tdep_pkg::RateW-1:0]    rate0, rate1;
  tdep_pkg::in_item_t            batch_held[$];
  tdep_pkg::out_item_t           placements_due[$];

  int                  n_errors = 0;
  int                  n_items = 0;
  int                  n_places = 0;
  int                  n_over = 0;
  int                  idle_cycles = 0;

  two_device_expert_placer_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // floor(size * 2^(2F) / rate), saturated to 64 bits
  function automatic logic [tdep_pkg::LoadW-1:0] xfer_time(
      input logic [tdep_pkg::SizeW-1:0] size, input logic [tdep_pkg::RateW-1:0] rate);
    logic [tdep_pkg::SizeW+2*tdep_pkg::FracBits-1:0] num, q, d;
    num = {size, {(2*tdep_pkg::FracBits){1'b0}}};
    d = (rate == '0) ? (1 << tdep_pkg::FracBits) : rate;
    q = num / d;
    return (q >> tdep_pkg::LoadW) != 0 ? '1 : q[tdep_pkg::LoadW-1:0];
  endfunction

  function automatic logic [tdep_pkg::LoadW-1:0] sat_sum(
      input logic [tdep_pkg::LoadW-1:0] a, input logic [tdep_pkg::LoadW-1:0] b);
    logic [tdep_pkg::LoadW:0] s;
    s = a + b;
    return s[tdep_pkg::LoadW] ? '1 : s[tdep_pkg::LoadW-1:0];
  endfunction

  function automatic bit ranks_ahead(input tdep_pkg::in_item_t a,
                                     input tdep_pkg::in_item_t b);
    if (a.hot != b.hot) return a.hot;
    if (a.recent_ns != b.recent_ns) return a.recent_ns > b.recent_ns;
    if (a.size_bytes != b.size_bytes) return a.size_bytes > b.size_bytes;
    return a.expert_id < b.expert_id;
  endfunction

  // sort the held batch and queue one placement per expert
  task automatic place_batch();
    tdep_pkg::in_item_t          order[$];
    tdep_pkg::in_item_t          e;
    logic [tdep_pkg::LoadW-1:0]  load0, load1, t0, t1;
    logic [tdep_pkg::TotW-1:0]   bytes0, bytes1;
    logic [6:0]                  cnt0, cnt1;
    logic                        can0, can1, dev;
    tdep_pkg::out_item_t         r;
    int                          j;
    foreach (batch_held[i]) begin
      j = order.size();
      while (j > 0 && ranks_ahead(batch_held[i], order[j-1])) j--;
      order.insert(j, batch_held[i]);
    end
    load0 = '0; load1 = '0; bytes0 = '0; bytes1 = '0; cnt0 = '0; cnt1 = '0;
    foreach (order[i]) begin
      e = order[i];
      t0 = xfer_time(e.size_bytes, rate0);
      t1 = xfer_time(e.size_bytes, rate1);
      can0 = ({1'b0, bytes0} + e.size_bytes) <= free0;
      can1 = ({1'b0, bytes1} + e.size_bytes) <= free1;
      if (can0 != can1) dev = can1;
      else if (!can0) dev = !(load0 <= load1);
      else dev = !(sat_sum(load0, t0) <= sat_sum(load1, t1));
      if (!dev) begin
        bytes0 = bytes0 + e.size_bytes; cnt0++; load0 = sat_sum(load0, t0);
      end else begin
        bytes1 = bytes1 + e.size_bytes; cnt1++; load1 = sat_sum(load1, t1);
      end
      r.expert_id_res = e.expert_id;
      r.device = dev;
      r.size_bytes_res = e.size_bytes;
      r.over_budget = !can0 && !can1;
      r.dev0_bytes_total = bytes0;
      r.dev1_bytes_total = bytes1;
      r.dev0_count = cnt0;
      r.dev1_count = cnt1;
      r.last_res = (i == order.size() - 1);
      placements_due.insert(placements_due.size(), r);
    end
    batch_held.delete();
  endtask

  // hold the item until the block takes it, then update the model
  task automatic send(input tdep_pkg::in_item_t it, input bit typed,
                      input tdep_pkg::out_item_t res);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_items++;
    if (typed) begin
      placements_due.insert(placements_due.size(), res);
    end else begin
      if (batch_held.size() < tdep_pkg::MaxExperts)
        batch_held.insert(batch_held.size(), it);
      if (it.last) place_batch();
    end
  endtask

  // drop start for a random gap now and then
  task automatic maybe_gap();
    if ($urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (busy || placements_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tdep_pkg::CfgIdxW-1:0] idx,
                           input logic [tdep_pkg::CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      tdep_pkg::REG_DEV0_FREE: free0 = val;
      tdep_pkg::REG_DEV1_FREE: free1 = val;
      tdep_pkg::REG_DEV0_RATE: rate0 = val[tdep_pkg::RateW-1:0];
      default:                 rate1 = val[tdep_pkg::RateW-1:0];
    endcase
  endtask

  task automatic configure(input logic [tdep_pkg::CfgW-1:0] f0,
                           input logic [tdep_pkg::CfgW-1:0] f1,
                           input logic [tdep_pkg::RateW-1:0] r0,
                           input logic [tdep_pkg::RateW-1:0] r1);
    write_reg(tdep_pkg::REG_DEV0_FREE, f0);
    write_reg(tdep_pkg::REG_DEV1_FREE, f1);
    write_reg(tdep_pkg::REG_DEV0_RATE, {16'b0, r0});
    write_reg(tdep_pkg::REG_DEV1_RATE, {16'b0, r1});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic tdep_pkg::in_item_t rand_item(input int mode);
    tdep_pkg::in_item_t it;
    it.expert_id = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 3))
                                             : 16'($urandom());
    it.hot = 1'($urandom_range(0, 1));
    it.recent_ns = $urandom_range(0, 1) ? 63'({$urandom(), $urandom()})
                                        : 63'($urandom_range(0, 3));
    case (mode)
      0: it.size_bytes = $urandom_range(0, 4) == 0 ? 48'($urandom_range(0, 2))
                                                   : 48'($urandom_range(1, 1 << 20));
      default: it.size_bytes = 48'({$urandom(), $urandom()});
    endcase
    it.last = 1'b0;
    return it;
  endfunction

  // check placements and watch for a stuck run
  always @(posedge clk) begin
    tdep_pkg::out_item_t x;
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
    if (rst_n && out_valid) begin
      if (placements_due.size() == 0) begin
        $error("placement with none expected: id %0h", out_item.expert_id_res);
        n_errors++;
      end else begin
        x = placements_due.pop_front();
        n_places++;
        if (x.over_budget) n_over++;
        if (out_item.expert_id_res !== x.expert_id_res) begin
          $error("expert_id_res exp %0h got %0h", x.expert_id_res, out_item.expert_id_res);
          n_errors++;
        end
        if (out_item.device !== x.device) begin
          $error("device exp %0d got %0d", x.device, out_item.device);
          n_errors++;
        end
        if (out_item.size_bytes_res !== x.size_bytes_res) begin
          $error("size_bytes_res exp %0h got %0h", x.size_bytes_res,
                 out_item.size_bytes_res);
          n_errors++;
        end
        if (out_item.over_budget !== x.over_budget) begin
          $error("over_budget exp %0d got %0d", x.over_budget, out_item.over_budget);
          n_errors++;
        end
        if (out_item.dev0_bytes_total !== x.dev0_bytes_total) begin
          $error("dev0_bytes_total exp %0h got %0h", x.dev0_bytes_total,
                 out_item.dev0_bytes_total);
          n_errors++;
        end
        if (out_item.dev1_bytes_total !== x.dev1_bytes_total) begin
          $error("dev1_bytes_total exp %0h got %0h", x.dev1_bytes_total,
                 out_item.dev1_bytes_total);
          n_errors++;
        end
        if (out_item.dev0_count !== x.dev0_count) begin
          $error("dev0_count exp %0d got %0d", x.dev0_count, out_item.dev0_count);
          n_errors++;
        end
        if (out_item.dev1_count !== x.dev1_count) begin
          $error("dev1_count exp %0d got %0d", x.dev1_count, out_item.dev1_count);
          n_errors++;
        end
        if (out_item.last_res !== x.last_res) begin
          $error("last_res exp %0d got %0d", x.last_res, out_item.last_res);
          n_errors++;
        end
      end
    end
  end

  initial begin
    row_t                 rows[$];
    row_t                 rw;
    tdep_pkg::out_item_t  none;
    tdep_pkg::in_item_t   it;
    int                   blen, mode, phase;
    none = '0;
    free0 = '0; free1 = '0; rate0 = 32'd65536; rate1 = 32'd65536;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows; register defaults: no budget, rate 1.0
    rw.typed = 1'b1;
    rw.item = '{expert_id: 16'h1234, hot: 1'b0, recent_ns: '0, size_bytes: '0, last: 1'b1};
    rw.res = '{expert_id_res: 16'h1234, device: 1'b0, size_bytes_res: '0,
               over_budget: 1'b0, dev0_bytes_total: '0, dev1_bytes_total: '0,
               dev0_count: 7'd1, dev1_count: 7'd0, last_res: 1'b1};
    rows.insert(rows.size(), rw);
    rw.item = '{expert_id: 16'hFFFF, hot: 1'b1, recent_ns: '1, size_bytes: '1, last: 1'b1};
    rw.res = '{expert_id_res: 16'hFFFF, device: 1'b0, size_bytes_res: '1,
               over_budget: 1'b1, dev0_bytes_total: {6'b0, {tdep_pkg::SizeW{1'b1}}},
               dev1_bytes_total: '0, dev0_count: 7'd1, dev1_count: 7'd0, last_res: 1'b1};
    rows.insert(rows.size(), rw);
    // ordering: hot, newer, larger, smaller id, equal keys keep arrival order
    rw.typed = 1'b0;
    rw.res = none;
    rw.item = '{expert_id: 16'd5, hot: 1'b0, recent_ns: 63'd9, size_bytes: 48'd7, last: 1'b0};
    rows.insert(rows.size(), rw);
    rw.item = '{expert_id: 16'd4, hot: 1'b1, recent_ns: 63'd1, size_bytes: 48'd7, last: 1'b0};
    rows.insert(rows.size(), rw);
    rw.item = '{expert_id: 16'd3, hot: 1'b1, recent_ns: 63'd2, size_bytes: 48'd7, last: 1'b0};
    rows.insert(rows.size(), rw);
    rw.item = '{expert_id: 16'd2, hot: 1'b1, recent_ns: 63'd2, size_bytes: 48'd9, last: 1'b0};
    rows.insert(rows.size(), rw);
    rw.item = '{expert_id: 16'd1, hot: 1'b1, recent_ns: 63'd2, size_bytes: 48'd9, last: 1'b0};
    rows.insert(rows.size(), rw);
    rw.item = '{expert_id: 16'd1, hot: 1'b1, recent_ns: 63'd2, size_bytes: 48'd9, last: 1'b0};
    rows.insert(rows.size(), rw);
    rw.item = '{expert_id: 16'd0, hot: 1'b0, recent_ns: '1, size_bytes: '0, last: 1'b1};
    rows.insert(rows.size(), rw);
    foreach (rows[i]) begin
      send(rows[i].item, rows[i].typed, rows[i].res);
      maybe_gap();
    end
    drain();

    // room on both devices, unequal rates
    configure(48'd100, 48'd100, 32'd65536, 32'd131072);
    rw.item = '{expert_id: 16'd7, hot: 1'b0, recent_ns: 63'd0, size_bytes: 48'd60, last: 1'b0};
    send(rw.item, 1'b0, none);
    rw.item = '{expert_id: 16'd8, hot: 1'b0, recent_ns: 63'd0, size_bytes: 48'd50, last: 1'b0};
    send(rw.item, 1'b0, none);
    rw.item = '{expert_id: 16'd9, hot: 1'b0, recent_ns: 63'd0, size_bytes: 48'd40, last: 1'b1};
    send(rw.item, 1'b0, none);
    drain();

    // random batches under a run of register settings
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: configure('1, '1, '0, '1);
        1: configure('0, '0, 32'd1, 32'd1);
        2: configure(48'd1 << 21, 48'd1 << 22, 32'd65536, 32'd65536);
        3: configure(48'($urandom_range(0, 1 << 23)), 48'($urandom_range(0, 1 << 23)),
                     $urandom(), $urandom());
        4: configure('1, 48'd1 << 20, '1, '0);
        5: configure(48'd3 << 20, '1, $urandom_range(1, 1 << 18), $urandom_range(1, 1 << 18));
        6: configure(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                     $urandom(), $urandom());
        default: configure(48'd1 << 22, 48'd1 << 21, 32'd32768, 32'd98304);
      endcase
      mode = (phase == 0 || phase == 6) ? 1 : 0;
      for (int b = 0; b < Batches; b++) begin
        // one overfull batch in two phases exercises the ignored descriptors
        blen = ((phase == 2 || phase == 6) && b == 0) ?
               $urandom_range(tdep_pkg::MaxExperts + 1, tdep_pkg::MaxExperts + 4) :
               $urandom_range(1, 6);
        for (int k = 0; k < blen; k++) begin
          it = rand_item(mode);
          it.last = (k == blen - 1);
          send(it, 1'b0, none);
          maybe_gap();
        end
      end
      drain();
    end

    $display("Sent %0d descriptors, checked %0d placements (%0d over budget)",
             n_items, n_places, n_over);
    $display("across 10 register settings, overfull batches included");
    if (n_errors == 0 && placements_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
